@@ rtl/core/voice_playback_scheduler_top_macros.svh @@
// Assertion macros used by the checker file.
`ifndef VOICE_PLAYBACK_SCHEDULER_TOP_MACROS_SVH
`define VOICE_PLAYBACK_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define VPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define VPS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/vps_pkg.sv @@
package vps_pkg;

	localparam int unsigned FRAME_SAMPLES  = 320;
	localparam int unsigned FRAME_MS       = 20;
	localparam int unsigned SAMPLES_PER_MS = 16;
	localparam int unsigned SPM_SHIFT      = 4;
	localparam int unsigned FRAME_LIMIT    = FRAME_SAMPLES / SAMPLES_PER_MS;
	localparam logic [31:0] FRAME_MS_NEG   = ~32'(FRAME_MS) + 32'd1;
	localparam int unsigned REG_START_TIME = 0;

	typedef enum logic [1:0] {
		OP_PLAY_NOW = 2'd0,
		OP_PLAY_AT  = 2'd1,
		OP_STOP     = 2'd2,
		OP_TICK     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ACT_SILENCE  = 3'd0,
		ACT_CONTINUE = 3'd1,
		ACT_PREEMPT  = 3'd2,
		ACT_CHAIN    = 3'd3,
		ACT_END      = 3'd4,
		ACT_STOP     = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_DIFF,
		ST_DUE,
		ST_ADV,
		ST_STOP
	} state_t;

	typedef struct packed {
		logic clear;
		logic pop;
		logic open;
		logic shift;
		logic place;
	} pend_cmd_t;

	typedef struct packed {
		logic        full;
		logic        empty;
		logic        at_zero;
		logic [31:0] cmp_time;
		logic [31:0] head_time;
		logic [7:0]  head_voice;
	} pend_stat_t;

	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} fifo_cmd_t;

	typedef struct packed {
		logic       full;
		logic       empty;
		logic [7:0] head_voice;
	} fifo_stat_t;

endpackage

@@ rtl/core/vps_in_if.sv @@
interface vps_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [7:0]  voice_id;
	logic [31:0] at_ms;
	logic [8:0]  samples_ready;

	modport source (output valid, op, voice_id, at_ms, samples_ready, input ready);
	modport sink (input valid, op, voice_id, at_ms, samples_ready, output ready);
endinterface

@@ rtl/core/vps_out_if.sv @@
interface vps_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [7:0]  voice_out;
	logic [8:0]  sample_offset;
	logic [31:0] frame_time_ms;

	modport source (output valid, action, voice_out, sample_offset, frame_time_ms, input ready);
	modport sink (input valid, action, voice_out, sample_offset, frame_time_ms, output ready);
endinterface

@@ rtl/core/vps_alu.sv @@
module vps_alu (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] diff,
	output logic        borrow
);
	// The borrow is set when a is below b as unsigned values.
	assign {borrow, diff} = {1'b0, a} - {1'b0, b};
endmodule

@@ rtl/core/vps_pend.sv @@
module vps_pend #(
	parameter int unsigned DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vps_pkg::pend_cmd_t cmd,
	input  logic [31:0]        ins_time,
	input  logic [7:0]         ins_voice,
	output vps_pkg::pend_stat_t stat
);
	import vps_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [31:0]   time_q  [DEPTH];
	logic [7:0]    voice_q [DEPTH];
	logic [31:0]   up_time [DEPTH];
	logic [7:0]    up_voice[DEPTH];
	logic [CW-1:0] count_q;
	logic [IW-1:0] pos_q;
	logic [IW-1:0] prev_idx;

	assign prev_idx = pos_q - 1'b1;

	for (genvar g = 0; g < DEPTH; g++) begin : g_up
		if (g < DEPTH - 1) begin : g_mid
			assign up_time[g]  = time_q[g + 1];
			assign up_voice[g] = voice_q[g + 1];
		end else begin : g_last
			assign up_time[g]  = time_q[g];
			assign up_voice[g] = voice_q[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q   <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.open) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.open) begin
				pos_q <= count_q[IW-1:0];
			end else if (cmd.shift) begin
				pos_q <= prev_idx;
			end
		end
	end

	// An insert walks from the tail toward the head, moving one entry per cycle.
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.pop) begin
				time_q[i]  <= up_time[i];
				voice_q[i] <= up_voice[i];
			end else if (cmd.shift && pos_q == IW'(i)) begin
				time_q[i]  <= time_q[prev_idx];
				voice_q[i] <= voice_q[prev_idx];
			end else if (cmd.place && pos_q == IW'(i)) begin
				time_q[i]  <= ins_time;
				voice_q[i] <= ins_voice;
			end
		end
	end

	assign stat.full       = (count_q == CW'(DEPTH));
	assign stat.empty      = (count_q == '0);
	assign stat.at_zero    = (pos_q == '0);
	assign stat.cmp_time   = time_q[prev_idx];
	assign stat.head_time  = time_q[0];
	assign stat.head_voice = voice_q[0];
endmodule

@@ rtl/core/vps_fifo.sv @@
module vps_fifo #(
	parameter int unsigned DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vps_pkg::fifo_cmd_t cmd,
	input  logic [7:0]         push_voice,
	output vps_pkg::fifo_stat_t stat
);
	import vps_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0]    mem_q [DEPTH];
	logic [IW-1:0] rd_q;
	logic [IW-1:0] wr_q;
	logic [IW-1:0] rd_inc;
	logic [IW-1:0] wr_inc;
	logic [CW-1:0] count_q;

	assign rd_inc = (rd_q == IW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
	assign wr_inc = (wr_q == IW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			wr_q    <= '0;
			count_q <= '0;
		end else if (cmd.clear) begin
			rd_q    <= '0;
			wr_q    <= '0;
			count_q <= '0;
		end else if (cmd.push) begin
			wr_q    <= wr_inc;
			count_q <= count_q + 1'b1;
		end else if (cmd.pop) begin
			rd_q    <= rd_inc;
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && !cmd.clear) begin
			mem_q[wr_q] <= push_voice;
		end
	end

	assign stat.full       = (count_q == CW'(DEPTH));
	assign stat.empty      = (count_q == '0);
	assign stat.head_voice = mem_q[rd_q];
endmodule

@@ rtl/core/voice_playback_scheduler_top.sv @@
// Play-now, and play-at on a full pending list, complete in the idle state; other play-at
// requests pass through the insert state, as the sorted insert compares one entry per cycle.
// Stop passes through the stop state, a tick through the diff, due and advance states, as the
// shared subtractor forms the time difference, due test and next frame head in turn; stop and
// advance wait for the output register. Asynchronous active-low reset empties both lists,
// stops the voice, clears the output valid flag and zeroes the start time and frame head.
module voice_playback_scheduler_top #(
	parameter int unsigned PENDING_DEPTH   = 4,
	parameter int unsigned IMMEDIATE_DEPTH = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	vps_in_if.sink       req,
	vps_out_if.source    rsp,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import vps_pkg::*;

	state_t      state_q;
	state_t      state_d;
	logic [31:0] start_q;
	logic [31:0] head_q;
	logic        playing_q;
	logic [31:0] at_q;
	logic [7:0]  vid_q;
	logic [8:0]  sready_q;
	logic [31:0] diff_q;
	logic        due_q;
	logic        out_valid_q;
	action_t     act_q;
	logic [7:0]  vout_q;
	logic [8:0]  off_q;
	logic [31:0] ftime_q;

	pend_cmd_t   pcmd;
	pend_stat_t  pstat;
	fifo_cmd_t   fcmd;
	fifo_stat_t  fstat;
	logic [31:0] alu_a;
	logic [31:0] alu_b;
	logic [31:0] alu_diff;
	logic        alu_borrow;

	logic        accept;
	logic        cfg_wr;
	logic        out_free;
	logic        emit;
	logic        play_d;
	action_t     dec_act;
	logic [7:0]  dec_voice;
	logic [8:0]  dec_off;
	logic        dec_play;
	logic        dec_ppop;
	logic        dec_fpop;
	logic [8:0]  pre_off;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'(REG_START_TIME));
	assign prdata   = (paddr[2] == 1'(REG_START_TIME)) ? start_q : '0;
	assign req.ready = (state_q == ST_IDLE);
	assign accept   = req.valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || rsp.ready;

	vps_alu u_alu (
		.a      (alu_a),
		.b      (alu_b),
		.diff   (alu_diff),
		.borrow (alu_borrow)
	);

	vps_pend #(.DEPTH(PENDING_DEPTH)) u_pend (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (pcmd),
		.ins_time  (at_q),
		.ins_voice (vid_q),
		.stat      (pstat)
	);

	vps_fifo #(.DEPTH(IMMEDIATE_DEPTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (fcmd),
		.push_voice (req.voice_id),
		.stat       (fstat)
	);

	// A due entry starts at its distance from the frame head in samples, limited to one frame.
	always_comb begin
		if (diff_q[31]) begin
			pre_off = '0;
		end else if (diff_q > 32'(FRAME_LIMIT)) begin
			pre_off = 9'(FRAME_SAMPLES);
		end else begin
			pre_off = 9'(diff_q[8:0] << SPM_SHIFT);
		end
	end

	always_comb begin
		dec_act   = ACT_SILENCE;
		dec_voice = '0;
		dec_off   = '0;
		dec_play  = playing_q;
		dec_ppop  = 1'b0;
		dec_fpop  = 1'b0;
		priority if (due_q) begin
			dec_act   = ACT_PREEMPT;
			dec_voice = pstat.head_voice;
			dec_off   = pre_off;
			dec_play  = 1'b1;
			dec_ppop  = 1'b1;
		end else if (playing_q) begin
			priority if (sready_q >= 9'(FRAME_SAMPLES)) begin
				dec_act = ACT_CONTINUE;
			end else if (!fstat.empty) begin
				dec_act   = ACT_CHAIN;
				dec_voice = fstat.head_voice;
				dec_off   = sready_q;
				dec_fpop  = 1'b1;
			end else begin
				dec_act  = ACT_END;
				dec_play = 1'b0;
			end
		end else if (!fstat.empty) begin
			dec_act   = ACT_CHAIN;
			dec_voice = fstat.head_voice;
			dec_play  = 1'b1;
			dec_fpop  = 1'b1;
		end else begin
			dec_act = ACT_SILENCE;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (op_t'(req.op))
						OP_PLAY_NOW: state_d = ST_IDLE;
						OP_PLAY_AT:  state_d = pstat.full ? ST_IDLE : ST_INS;
						OP_STOP:     state_d = ST_STOP;
						OP_TICK:     state_d = ST_DIFF;
					endcase
				end
			end
			ST_INS: begin
				if (pstat.at_zero || !alu_borrow) begin
					state_d = ST_IDLE;
				end
			end
			ST_DIFF: state_d = ST_DUE;
			ST_DUE:  state_d = ST_ADV;
			ST_ADV: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_STOP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pcmd   = '0;
		fcmd   = '0;
		alu_a  = head_q;
		alu_b  = FRAME_MS_NEG;
		emit   = 1'b0;
		play_d = playing_q;
		unique case (state_q)
			ST_IDLE: begin
				fcmd.push = accept && (op_t'(req.op) == OP_PLAY_NOW) && !fstat.full;
				pcmd.open = accept && (op_t'(req.op) == OP_PLAY_AT) && !pstat.full;
			end
			ST_INS: begin
				alu_a      = at_q;
				alu_b      = pstat.cmp_time;
				pcmd.shift = !pstat.at_zero && alu_borrow;
				pcmd.place = pstat.at_zero || !alu_borrow;
			end
			ST_DIFF: begin
				alu_a = pstat.head_time;
				alu_b = head_q;
			end
			ST_DUE: begin
				alu_a = 32'(FRAME_MS);
				alu_b = diff_q;
			end
			ST_ADV: begin
				emit     = out_free;
				pcmd.pop = out_free && dec_ppop;
				fcmd.pop = out_free && dec_fpop;
				play_d   = out_free ? dec_play : playing_q;
			end
			ST_STOP: begin
				emit       = out_free;
				pcmd.clear = out_free;
				fcmd.clear = out_free;
				play_d     = out_free ? 1'b0 : playing_q;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= '0;
			head_q      <= '0;
			playing_q   <= 1'b0;
			due_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			playing_q <= play_d;
			if (cfg_wr) begin
				start_q <= pwdata;
				head_q  <= pwdata;
			end else if (state_q == ST_ADV && out_free) begin
				head_q <= alu_diff;
			end
			if (state_q == ST_DUE) begin
				due_q <= !pstat.empty && !alu_diff[31];
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			at_q     <= req.at_ms;
			vid_q    <= req.voice_id;
			sready_q <= req.samples_ready;
		end
		if (state_q == ST_DIFF) begin
			diff_q <= alu_diff;
		end
		if (emit) begin
			ftime_q <= head_q;
			if (state_q == ST_STOP) begin
				act_q  <= ACT_STOP;
				vout_q <= '0;
				off_q  <= '0;
			end else begin
				act_q  <= dec_act;
				vout_q <= dec_voice;
				off_q  <= dec_off;
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.action        = act_q;
	assign rsp.voice_out     = vout_q;
	assign rsp.sample_offset = off_q;
	assign rsp.frame_time_ms = ftime_q;
endmodule

@@ rtl/core/vps_chk.sv @@
`include "voice_playback_scheduler_top_macros.svh"

module vps_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  req_op,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_action,
	input logic [7:0]  rsp_voice_out,
	input logic [8:0]  rsp_sample_offset,
	input logic [31:0] rsp_frame_time_ms,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);
	import vps_pkg::*;

	`VPS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_action) && $stable(rsp_voice_out) && $stable(rsp_sample_offset) && $stable(rsp_frame_time_ms), "response changed while stalled")
	`VPS_ASSERT_NXT(a_tick_busy, req_valid && req_ready && req_op == OP_TICK, !req_ready, "request taken during tick evaluation")
	`VPS_ASSERT_IMP(a_plain_zero, rsp_valid && (rsp_action == ACT_SILENCE || rsp_action == ACT_CONTINUE || rsp_action == ACT_END || rsp_action == ACT_STOP), rsp_voice_out == 8'd0 && rsp_sample_offset == 9'd0, "nonzero voice or offset on a non-start action")
	`VPS_ASSERT_NXT(a_cfg_read, psel && penable && pwrite && !paddr[2], paddr[2] || prdata == $past(pwdata), "start time readback mismatch")
endmodule

bind voice_playback_scheduler_top vps_chk u_vps_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_op            (req.op),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_action        (rsp.action),
	.rsp_voice_out     (rsp.voice_out),
	.rsp_sample_offset (rsp.sample_offset),
	.rsp_frame_time_ms (rsp.frame_time_ms),
	.psel              (psel),
	.penable           (penable),
	.pwrite            (pwrite),
	.paddr             (paddr),
	.pwdata            (pwdata),
	.prdata            (prdata)
);

@@ verif/voice_playback_scheduler_top_test.sv @@
`timescale 1ns / 100ps

module voice_playback_scheduler_top_test;
	import vps_pkg::*;

	localparam int PEND_DEPTH      = 4;
	localparam int IMM_DEPTH       = 8;
	localparam int SETTLE_CYCLES   = 12;
	localparam int RSP_HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT     = 100000;

	typedef struct packed {
		op_t         op;
		logic [7:0]  voice;
		logic [31:0] at;
		logic [8:0]  ready;
	} sched_req_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  voice;
		logic [8:0]  offset;
		logic [31:0] frame_time;
	} sched_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	vps_in_if  req_if ();
	vps_out_if rsp_if ();

	voice_playback_scheduler_top #(
		.PENDING_DEPTH  (PEND_DEPTH),
		.IMMEDIATE_DEPTH(IMM_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	logic [31:0] sched_pend_time [PEND_DEPTH];
	logic [7:0]  sched_pend_voice [PEND_DEPTH];
	int          sched_pend_cnt;
	logic [7:0]  sched_imm_voice [IMM_DEPTH];
	int          sched_imm_cnt;
	logic [31:0] sched_head;
	bit          sched_playing;

	sched_result_t expected_decisions [$];
	sched_result_t want;

	bit   req_idle;
	bit   rsp_idle;
	logic hold_rsp_req;
	int   err_cnt;
	int   sent_cnt;
	int   checked_cnt;
	int   cycle_cnt;
	int   act_seen [6];

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic sched_req_t make_req(input op_t op, input logic [7:0] voice,
			input logic [31:0] at, input logic [8:0] ready);
		sched_req_t rq;
		rq.op = op;
		rq.voice = voice;
		rq.at = at;
		rq.ready = ready;
		return rq;
	endfunction

	function automatic logic [7:0] pop_immediate();
		logic [7:0] v;
		v = sched_imm_voice[0];
		for (int i = 1; i < sched_imm_cnt; i++) begin
			sched_imm_voice[i - 1] = sched_imm_voice[i];
		end
		sched_imm_cnt--;
		return v;
	endfunction

	// Returns 1 when the request produces a decision, and updates the scheduler state.
	function automatic bit decide_action(input sched_req_t rq, output sched_result_t res);
		logic [31:0] head;
		logic [31:0] lead;
		logic [63:0] offs;
		int k;
		head = sched_head;
		res.action = ACT_SILENCE;
		res.voice = 8'd0;
		res.offset = 9'd0;
		res.frame_time = head;
		case (rq.op)
			OP_PLAY_NOW: begin
				if (sched_imm_cnt < IMM_DEPTH) begin
					sched_imm_voice[sched_imm_cnt] = rq.voice;
					sched_imm_cnt++;
				end
				return 1'b0;
			end
			OP_PLAY_AT: begin
				if (sched_pend_cnt < PEND_DEPTH) begin
					k = sched_pend_cnt;
					sched_pend_cnt++;
					while (k > 0 && sched_pend_time[k - 1] > rq.at) begin
						sched_pend_time[k] = sched_pend_time[k - 1];
						sched_pend_voice[k] = sched_pend_voice[k - 1];
						k--;
					end
					sched_pend_time[k] = rq.at;
					sched_pend_voice[k] = rq.voice;
				end
				return 1'b0;
			end
			OP_STOP: begin
				sched_pend_cnt = 0;
				sched_imm_cnt = 0;
				sched_playing = 1'b0;
				res.action = ACT_STOP;
				return 1'b1;
			end
			default: begin
				lead = head + FRAME_MS - sched_pend_time[0];
				if (sched_pend_cnt > 0 && !lead[31]) begin
					lead = sched_pend_time[0] - head;
					offs = lead[31] ? 64'd0 : {32'd0, lead} * SAMPLES_PER_MS;
					if (offs > FRAME_SAMPLES) offs = FRAME_SAMPLES;
					res.action = ACT_PREEMPT;
					res.voice = sched_pend_voice[0];
					res.offset = offs[8:0];
					for (int i = 1; i < sched_pend_cnt; i++) begin
						sched_pend_time[i - 1] = sched_pend_time[i];
						sched_pend_voice[i - 1] = sched_pend_voice[i];
					end
					sched_pend_cnt--;
					sched_playing = 1'b1;
				end else if (sched_playing) begin
					if (rq.ready >= FRAME_SAMPLES) begin
						res.action = ACT_CONTINUE;
					end else if (sched_imm_cnt > 0) begin
						res.action = ACT_CHAIN;
						res.voice = pop_immediate();
						res.offset = rq.ready;
					end else begin
						sched_playing = 1'b0;
						res.action = ACT_END;
					end
				end else if (sched_imm_cnt > 0) begin
					res.action = ACT_CHAIN;
					res.voice = pop_immediate();
					sched_playing = 1'b1;
				end
				sched_head = head + FRAME_MS;
				return 1'b1;
			end
		endcase
	endfunction

	function automatic sched_req_t random_request();
		sched_req_t rq;
		int pick;
		rq.op = OP_TICK;
		rq.voice = 8'($urandom_range(0, 255));
		rq.at = $urandom();
		rq.ready = 9'($urandom_range(0, 511));
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			rq.op = OP_STOP;
		end else if (pick < 20) begin
			rq.op = OP_PLAY_NOW;
		end else if (pick < 36) begin
			rq.op = OP_PLAY_AT;
			pick = $urandom_range(0, 9);
			if (pick >= 1 && pick < 3) begin
				rq.at = sched_head - 32'($urandom_range(0, 40));
			end else if (pick >= 3) begin
				rq.at = sched_head + 32'($urandom_range(0, 80));
			end
		end else begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				rq.ready = 9'($urandom_range(FRAME_SAMPLES, 511));
			end else if (pick == 4) begin
				rq.ready = 9'd0;
			end else if (pick < 9) begin
				rq.ready = 9'($urandom_range(0, FRAME_SAMPLES - 1));
			end
		end
		return rq;
	endfunction

	task automatic send_request(input sched_req_t rq);
		int gap;
		sched_result_t res;
		gap = req_idle ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.op <= rq.op;
		req_if.voice_id <= rq.voice;
		req_if.at_ms <= rq.at;
		req_if.samples_ready <= rq.ready;
		do @(posedge clk); while (!req_if.ready);
		if (decide_action(rq, res)) begin
			expected_decisions.push_back(res);
		end
		sent_cnt++;
	endtask

	task automatic drain_decisions();
		req_if.valid <= 1'b0;
		while (expected_decisions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_start_time(input logic [31:0] value);
		drain_decisions();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(REG_START_TIME * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sched_head = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			$error("start_time_ms: expected %0h, actual %0h", value, prdata);
			err_cnt++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_immediate_chain();
		program_start_time(32'd0);
		req_idle = 1'b1;
		rsp_idle = 1'b1;
		send_request(make_req(OP_TICK, 8'h00, 32'h0000_0000, 9'd0));
		send_request(make_req(OP_PLAY_NOW, 8'hFF, 32'hFFFF_FFFF, 9'd511));
		send_request(make_req(OP_TICK, 8'h00, 32'h0000_0000, 9'd0));
		send_request(make_req(OP_TICK, 8'h00, 32'h0000_0000, 9'd511));
		send_request(make_req(OP_PLAY_NOW, 8'h00, 32'h0000_0000, 9'd0));
		send_request(make_req(OP_TICK, 8'h00, 32'h0000_0000, 9'd319));
		send_request(make_req(OP_TICK, 8'h00, 32'h0000_0000, 9'd0));
	endtask

	task automatic test_timed_preempt();
		program_start_time(32'd1000);
		send_request(make_req(OP_PLAY_AT, 8'hAA, 32'd1005, 9'd0));
		send_request(make_req(OP_PLAY_AT, 8'h55, 32'd1005, 9'd0));
		send_request(make_req(OP_PLAY_AT, 8'h11, 32'd1060, 9'd0));
		send_request(make_req(OP_PLAY_AT, 8'h22, 32'hFFFF_FFFF, 9'd0));
		send_request(make_req(OP_PLAY_AT, 8'h33, 32'h0000_0000, 9'd0));
		send_request(make_req(OP_TICK, 8'h00, 32'h0, 9'd320));
		send_request(make_req(OP_TICK, 8'h00, 32'h0, 9'd320));
		send_request(make_req(OP_TICK, 8'h00, 32'h0, 9'd320));
		send_request(make_req(OP_TICK, 8'h00, 32'h0, 9'd320));
		send_request(make_req(OP_TICK, 8'h00, 32'h0, 9'd100));
	endtask

	task automatic test_full_lists_and_stop();
		program_start_time(32'hFFFF_FFFF);
		for (int i = 0; i < IMM_DEPTH + 1; i++) begin
			send_request(make_req(OP_PLAY_NOW, 8'(i * 37), 32'h0, 9'd0));
		end
		send_request(make_req(OP_STOP, 8'hFF, 32'hFFFF_FFFF, 9'd511));
		send_request(make_req(OP_TICK, 8'h00, 32'h0, 9'd0));
	endtask

	task automatic test_output_stall();
		program_start_time(32'hFFFF_FFF0);
		req_idle = 1'b0;
		hold_rsp_req <= 1'b1;
		for (int i = 0; i < 40; i++) begin
			if (i % 4 == 1) begin
				send_request(make_req(OP_PLAY_NOW, 8'($urandom_range(0, 255)), 32'h0, 9'd0));
			end else begin
				send_request(make_req(OP_TICK, 8'h00, 32'h0, 9'($urandom_range(0, 511))));
			end
		end
	endtask

	task automatic test_random_traffic(input logic [31:0] start, input int count,
			input bit idle_in, input bit idle_out);
		program_start_time(start);
		req_idle = idle_in;
		rsp_idle = idle_out;
		for (int i = 0; i < count; i++) begin
			send_request(random_request());
		end
	endtask

	initial begin : rsp_sink
		int gap;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rsp_req) begin
				hold_rsp_req <= 1'b0;
				rsp_if.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
			end
			gap = rsp_idle ? $urandom_range(0, 3) : 0;
			if (gap > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_decisions.size() == 0) begin
				$error("unexpected decision: action %0d, voice %0d", rsp_if.action,
					rsp_if.voice_out);
				err_cnt++;
			end else begin
				want = expected_decisions.pop_front();
				checked_cnt++;
				act_seen[want.action]++;
				if (rsp_if.action !== want.action) begin
					$error("action: expected %0d, actual %0d", want.action, rsp_if.action);
					err_cnt++;
				end
				if (rsp_if.voice_out !== want.voice) begin
					$error("voice_out: expected %0d, actual %0d", want.voice,
						rsp_if.voice_out);
					err_cnt++;
				end
				if (rsp_if.sample_offset !== want.offset) begin
					$error("sample_offset: expected %0d, actual %0d", want.offset,
						rsp_if.sample_offset);
					err_cnt++;
				end
				if (rsp_if.frame_time_ms !== want.frame_time) begin
					$error("frame_time_ms: expected %0h, actual %0h", want.frame_time,
						rsp_if.frame_time_ms);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_if.valid = 1'b0;
		req_if.op = OP_PLAY_NOW;
		req_if.voice_id = '0;
		req_if.at_ms = '0;
		req_if.samples_ready = '0;
		hold_rsp_req = 1'b0;
		req_idle = 1'b1;
		rsp_idle = 1'b1;
		err_cnt = 0;
		sent_cnt = 0;
		checked_cnt = 0;
		cycle_cnt = 0;
		foreach (act_seen[i]) act_seen[i] = 0;
		sched_pend_cnt = 0;
		sched_imm_cnt = 0;
		sched_head = 32'd0;
		sched_playing = 1'b0;
		foreach (sched_pend_time[i]) begin
			sched_pend_time[i] = '0;
			sched_pend_voice[i] = '0;
		end
		foreach (sched_imm_voice[i]) sched_imm_voice[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_immediate_chain();
		test_timed_preempt();
		test_full_lists_and_stop();
		test_output_stall();
		test_random_traffic(32'd0, 200, 1'b1, 1'b1);
		test_random_traffic(32'h7FFF_FFF0, 200, 1'b0, 1'b0);
		test_random_traffic(32'hFFFF_FFFF, 200, 1'b1, 1'b0);
		test_random_traffic($urandom(), 200, 1'b0, 1'b1);
		test_random_traffic(32'hFFFF_FFD8, 200, 1'b1, 1'b1);
		drain_decisions();

		$display("tb: %0d requests sent across seven start times, %0d decisions checked",
			sent_cnt, checked_cnt);
		$display("tb: silence %0d, continue %0d, preempt %0d, chain %0d, end %0d, stop %0d",
			act_seen[ACT_SILENCE], act_seen[ACT_CONTINUE], act_seen[ACT_PREEMPT],
			act_seen[ACT_CHAIN], act_seen[ACT_END], act_seen[ACT_STOP]);
		if (err_cnt == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
